// ===== src/lbps_pkg.sv =====
// Package for the LED blink pattern sequencer: codes, widths and pattern ROMs.
// No dependencies; used by led_blink_pattern_sequencer.
`default_nettype none
package lbps_pkg;

  localparam int PATTERN_SLOTS = 16;
  localparam int BIDX_W = $clog2(PATTERN_SLOTS);
  localparam int BLEN_W = $clog2(PATTERN_SLOTS + 1);

  // overlay patterns are short: at most 7 slots, always below PATTERN_SLOTS
  localparam int OV_IDX_W = 3;
  localparam int OV_SLOTS = 1 << OV_IDX_W;

  localparam int TIME_W   = 32;
  localparam int PERIOD_W = 24;
  localparam int CNT_W    = $clog2(TIME_W);

  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(100000);

  // input modes
  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_STATE = 3'd1;
  localparam logic [2:0] MODE_BOOT  = 3'd2;
  localparam logic [2:0] MODE_CMD   = 3'd3;
  localparam logic [2:0] MODE_BTN   = 3'd4;

  // base states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CAPTURE = 3'd1;
  localparam logic [2:0] ST_ERROR   = 3'd2;
  localparam logic [2:0] ST_HOST    = 3'd3;
  localparam logic [2:0] ST_BOOT    = 3'd4;

  // boot blink choice
  localparam logic [1:0] BOOT_NONE  = 2'd0;
  localparam logic [1:0] BOOT_ONE   = 2'd1;
  localparam logic [1:0] BOOT_TWO   = 2'd2;
  localparam logic [1:0] BOOT_THREE = 2'd3;

  // overlay kinds
  localparam logic [1:0] OV_NONE = 2'd0;
  localparam logic [1:0] OV_CMD  = 2'd1;
  localparam logic [1:0] OV_BTN  = 2'd2;

  typedef struct packed {
    logic [PATTERN_SLOTS-1:0] bits;
    logic [BLEN_W-1:0]        len;
  } base_pat_t;

  typedef struct packed {
    logic [OV_SLOTS-1:0] bits;
    logic [OV_IDX_W-1:0] len;
  } ov_pat_t;

  // bit i of a pattern is slot i
  function automatic base_pat_t base_pattern(logic [2:0] st, logic [1:0] choice);
    logic [63:0] raw_bits;
    int unsigned raw_len;
    base_pat_t   p;
    raw_bits = '0;
    raw_len  = 0;
    case (st)
      ST_IDLE: begin
        raw_bits = 64'h1;  raw_len = 1;
      end
      ST_CAPTURE: begin
        raw_bits = 64'h1F; raw_len = 10;
      end
      ST_ERROR: begin
        raw_bits = 64'h15; raw_len = 16;
      end
      ST_HOST: begin
        raw_bits = 64'h3;  raw_len = 10;
      end
      ST_BOOT: begin
        case (choice)
          BOOT_ONE: begin
            raw_bits = 64'h1;  raw_len = 8;
          end
          BOOT_TWO: begin
            raw_bits = 64'h5;  raw_len = 10;
          end
          BOOT_THREE: begin
            raw_bits = 64'h15; raw_len = 12;
          end
          default: begin
            raw_bits = '0;     raw_len = 0;
          end
        endcase
      end
      default: begin
        raw_bits = '0; raw_len = 0;
      end
    endcase
    p.bits = raw_bits[PATTERN_SLOTS-1:0];
    p.len  = (raw_len > PATTERN_SLOTS) ? BLEN_W'(PATTERN_SLOTS) : BLEN_W'(raw_len);
    return p;
  endfunction

  function automatic ov_pat_t ov_pattern(logic [1:0] kind);
    ov_pat_t p;
    case (kind)
      OV_CMD: begin
        p.bits = OV_SLOTS'(8'h05); p.len = OV_IDX_W'(3);
      end
      OV_BTN: begin
        p.bits = OV_SLOTS'(8'h3E); p.len = OV_IDX_W'(7);
      end
      default: begin
        p.bits = '0;               p.len = '0;
      end
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== src/led_blink_pattern_sequencer.sv =====
// LED blink pattern sequencer top level: state, sequencer and shared radix-2 divider.
// Depends on lbps_pkg.
//
// Usage:
//   Input words (in_valid_i/in_stall_o) carry a mode, a microsecond timestamp,
//   a base state and a boot blink count. Every word yields exactly one output
//   word (out_valid_o/out_stall_i side): the LED level and the overlay flag.
//   A service tick runs the elapsed time through a restoring divider, one
//   quotient bit per cycle; the same loop reduces the slot count modulo the
//   base pattern length. After the divide, a tick passes through an update
//   step and then the output step; every other mode goes straight from accept
//   to the output step. The divider is the only iterative unit.
//   in_stall_o is high while a word is in flight. The result sits in an output
//   register; if the receiver stalls, the sequencer holds at its last step until
//   the previous result is taken, so no word is dropped.
//   cfg_we_i writes the slot period; write it only while the block is idle.
//   Reset: idle state, no overlay, LED off, slot period 100000 us, no pending
//   output; no clearing pass.
`default_nettype none
module led_blink_pattern_sequencer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lbps_pkg::PERIOD_W-1:0] cfg_slot_period_us_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [2:0]                    mode_i,
  input  wire logic [lbps_pkg::TIME_W-1:0]   now_us_i,
  input  wire logic [2:0]                    new_state_i,
  input  wire logic [7:0]                    blink_count_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               led_on_o,
  output logic                               overlay_active_o
);

  localparam int TW = lbps_pkg::TIME_W;
  localparam int PW = lbps_pkg::PERIOD_W;
  localparam int BW = lbps_pkg::BLEN_W;
  localparam int IW = lbps_pkg::BIDX_W;
  localparam int OW = lbps_pkg::OV_IDX_W;
  localparam int CW = lbps_pkg::CNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  // control state
  logic [1:0]    fsm_q, fsm_d;
  logic [PW-1:0] period_q, period_d;
  logic [2:0]    base_q, base_d;
  logic [1:0]    choice_q, choice_d;
  logic [IW-1:0] bidx_q, bidx_d;
  logic [1:0]    ov_kind_q, ov_kind_d;
  logic [OW-1:0] ov_idx_q, ov_idx_d;
  logic [TW-1:0] last_q, last_d;
  logic          led_q, led_d;
  logic          refresh_q, refresh_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;

  // datapath
  logic [TW-1:0] now_q, now_d;
  logic [TW-1:0] dvd_q, dvd_d;
  logic [PW-1:0] rem_q, rem_d;
  logic [BW-1:0] modr_q, modr_d;
  logic          out_led_q, out_led_d;
  logic          out_ov_q, out_ov_d;

  lbps_pkg::base_pat_t bpat;
  lbps_pkg::ov_pat_t   opat;

  logic [PW-1:0] period_eff;
  logic [PW:0]   rem_sh;
  logic          q_bit;
  logic [BW:0]   modr_sh;
  logic          ov_run;
  logic          level;
  logic [OW-1:0] ov_left;
  logic [BW:0]   bsum;
  logic          in_acc;
  logic          out_free;

  assign bpat       = lbps_pkg::base_pattern(base_q, choice_q);
  assign opat       = lbps_pkg::ov_pattern(ov_kind_q);
  assign period_eff = (period_q == '0) ? PW'(1) : period_q;

  // one restoring step: remainder shift, compare, subtract
  assign rem_sh  = {rem_q, dvd_q[TW-1]};
  assign q_bit   = (rem_sh >= {1'b0, period_eff});
  // running quotient modulo base length, fed one quotient bit at a time
  assign modr_sh = {modr_q, q_bit};

  assign ov_run  = (opat.len != '0) && (ov_idx_q < opat.len);
  assign ov_left = opat.len - ov_idx_q;
  assign bsum    = {1'b0, BW'(bidx_q)} + {1'b0, modr_q};

  always_comb begin
    if (ov_run) begin
      level = opat.bits[ov_idx_q];
    end else if ((bpat.len != '0) && ({1'b0, bidx_q} < bpat.len)) begin
      level = bpat.bits[bidx_q];
    end else begin
      level = 1'b0;
    end
  end

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    fsm_d       = fsm_q;
    period_d    = cfg_we_i ? cfg_slot_period_us_i : period_q;
    base_d      = base_q;
    choice_d    = choice_q;
    bidx_d      = bidx_q;
    ov_kind_d   = ov_kind_q;
    ov_idx_d    = ov_idx_q;
    last_d      = last_q;
    led_d       = led_q;
    refresh_d   = refresh_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    now_d       = now_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    modr_d      = modr_q;
    out_led_d   = out_led_q;
    out_ov_d    = out_ov_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (fsm_q)
      S_IDLE: begin
        if (in_acc) begin
          now_d     = now_us_i;
          refresh_d = 1'b0;
          fsm_d     = S_OUT;
          case (mode_i)
            lbps_pkg::MODE_TICK: begin
              dvd_d  = now_us_i - last_q;
              rem_d  = '0;
              modr_d = '0;
              cnt_d  = '0;
              fsm_d  = S_DIV;
            end
            lbps_pkg::MODE_STATE: begin
              if ((new_state_i <= lbps_pkg::ST_BOOT) && (new_state_i != base_q)) begin
                base_d    = new_state_i;
                bidx_d    = '0;
                last_d    = now_us_i;
                refresh_d = 1'b1;
              end
            end
            lbps_pkg::MODE_BOOT: begin
              if (blink_count_i >= 8'd3) begin
                choice_d = lbps_pkg::BOOT_THREE;
              end else if (blink_count_i == 8'd2) begin
                choice_d = lbps_pkg::BOOT_TWO;
              end else begin
                choice_d = lbps_pkg::BOOT_ONE;
              end
              base_d    = lbps_pkg::ST_BOOT;
              bidx_d    = '0;
              last_d    = now_us_i;
              refresh_d = 1'b1;
            end
            lbps_pkg::MODE_CMD, lbps_pkg::MODE_BTN: begin
              ov_kind_d = (mode_i == lbps_pkg::MODE_CMD) ? lbps_pkg::OV_CMD
                                                         : lbps_pkg::OV_BTN;
              ov_idx_d  = '0;
              last_d    = now_us_i;
              refresh_d = 1'b1;
            end
            default: begin
              refresh_d = 1'b0;
            end
          endcase
        end
      end
      S_DIV: begin
        rem_d = q_bit ? PW'(rem_sh - {1'b0, period_eff}) : rem_sh[PW-1:0];
        dvd_d = {dvd_q[TW-2:0], q_bit};
        // modr < len, so one subtract keeps it reduced
        modr_d = (modr_sh >= {1'b0, bpat.len}) ? BW'(modr_sh - {1'b0, bpat.len})
                                               : modr_sh[BW-1:0];
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(TW - 1)) begin
          fsm_d = S_UPD;
        end
      end
      S_UPD: begin
        // dvd_q holds the slot count, rem_q the carried remainder
        if (dvd_q != '0) begin
          refresh_d = 1'b1;
          last_d    = now_q - {{(TW-PW){1'b0}}, rem_q};
          if (ov_run) begin
            if (dvd_q >= {{(TW-OW){1'b0}}, ov_left}) begin
              ov_kind_d = lbps_pkg::OV_NONE;
              ov_idx_d  = '0;
              bidx_d    = '0;
            end else begin
              ov_idx_d = ov_idx_q + dvd_q[OW-1:0];
            end
          end else if (bpat.len != '0) begin
            bidx_d = (bsum >= {1'b0, bpat.len}) ? IW'(bsum - {1'b0, bpat.len})
                                                : bsum[IW-1:0];
          end
        end
        fsm_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          led_d       = refresh_q ? level : led_q;
          out_led_d   = refresh_q ? level : led_q;
          out_ov_d    = (ov_kind_q != lbps_pkg::OV_NONE);
          out_valid_d = 1'b1;
          fsm_d       = S_IDLE;
        end
      end
      default: begin
        fsm_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= S_IDLE;
      period_q    <= lbps_pkg::PERIOD_RST;
      base_q      <= lbps_pkg::ST_IDLE;
      choice_q    <= lbps_pkg::BOOT_NONE;
      bidx_q      <= '0;
      ov_kind_q   <= lbps_pkg::OV_NONE;
      ov_idx_q    <= '0;
      last_q      <= '0;
      led_q       <= 1'b0;
      refresh_q   <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      period_q    <= period_d;
      base_q      <= base_d;
      choice_q    <= choice_d;
      bidx_q      <= bidx_d;
      ov_kind_q   <= ov_kind_d;
      ov_idx_q    <= ov_idx_d;
      last_q      <= last_d;
      led_q       <= led_d;
      refresh_q   <= refresh_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    modr_q    <= modr_d;
    out_led_q <= out_led_d;
    out_ov_q  <= out_ov_d;
  end

  assign in_stall_o       = (fsm_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign led_on_o         = out_led_q;
  assign overlay_active_o = out_ov_q;

  // a word in flight blocks the next one
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input accepted while a word was in flight");

  // a running overlay never points past its pattern
  a_ov_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_kind_q != lbps_pkg::OV_NONE) |-> (ov_idx_q < opat.len))
    else $error("overlay index out of range");

  // base index stays inside the base pattern
  a_bidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bpat.len != '0) |-> ({1'b0, bidx_q} < bpat.len))
    else $error("base index out of range");

  // a pending result is never overwritten
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_led_q)
                                      && $stable(out_ov_q)))
    else $error("stalled result changed");

endmodule
`default_nettype wire
